// ===== src/indexed_sequence_store_defines.svh =====
// Assertion macros for the checker of the sequence store.
`ifndef INDEXED_SEQUENCE_STORE_DEFINES_SVH
`define INDEXED_SEQUENCE_STORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define ISQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ISQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/isq_pkg.sv =====
// Types, codes and sizes shared by the sequence store modules.
package isq_pkg;

    localparam int CAPACITY  = 32;
    localparam int POS_W     = 6;
    localparam int OUT_CNT_W = 6;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Action codes
    localparam logic [3:0] ACT_APPEND    = 4'd0;
    localparam logic [3:0] ACT_PREPEND   = 4'd1;
    localparam logic [3:0] ACT_REM_FIRST = 4'd2;
    localparam logic [3:0] ACT_REM_LAST  = 4'd3;
    localparam logic [3:0] ACT_READ      = 4'd4;
    localparam logic [3:0] ACT_WRITE     = 4'd5;
    localparam logic [3:0] ACT_INSERT    = 4'd6;
    localparam logic [3:0] ACT_REM_AT    = 4'd7;
    localparam logic [3:0] ACT_REVERSE   = 4'd8;
    localparam logic [3:0] ACT_CLEAR     = 4'd9;
    localparam logic [3:0] ACT_SORT      = 4'd10;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INDEX = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef logic signed [31:0] t_word;

    // Source select of one cell for the coming cycle
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_LOAD,
        CMD_PREV,
        CMD_NEXT,
        CMD_HEAD
    } t_cell_cmd;

    typedef struct packed {
        logic [3:0]       action;
        logic [POS_W-1:0] position;
        t_word            item_value;
    } t_req;

    typedef struct packed {
        logic [1:0]           status;
        t_word                read_value;
        t_word                first_value;
        t_word                last_value;
        logic [OUT_CNT_W-1:0] count;
    } t_rsp;

endpackage

// ===== src/isq_cell.sv =====
// One storage cell of the element chain, with its neighbor compare.
module isq_cell import isq_pkg::*; (
    input  logic      i_clk,
    input  t_cell_cmd i_cmd,
    input  t_word     i_val,
    input  t_word     i_prev,
    input  t_word     i_next,
    input  t_word     i_head,
    output t_word     o_data,
    output logic      o_gt_next
);

    t_word r_data;
    t_word n_data;

    // Pick the source for this cell
    always_comb begin
        unique case (i_cmd)
            CMD_HOLD: n_data = r_data;
            CMD_LOAD: n_data = i_val;
            CMD_PREV: n_data = i_prev;
            CMD_NEXT: n_data = i_next;
            CMD_HEAD: n_data = i_head;
            default:  n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data    = r_data;
    assign o_gt_next = (r_data > i_next);

endmodule

// ===== src/indexed_sequence_store.sv =====
// Top level of the sequence store: request channel, cell chain, sequencer, result register.
//
// Ordered store of up to CAPACITY signed 32-bit values, one element per cell.
// Requests arrive on i_valid/o_ready with i_data (action, position,
// item_value); each request yields one result on o_valid/i_ready with o_data
// (status, read_value, first_value, last_value, count).
// A request is taken only while the sequencer is idle. Append, prepend and
// insert shift the cells above the position up by one place in parallel;
// remove first and remove at shift them down, write loads one cell, and
// read, remove last and clear move no cell. Reverse rotates the shrinking
// prefix once a cycle; sort runs count odd-even compare-exchange rounds over
// neighbor cells. Failed requests leave the store unchanged and report their
// status. Reset empties the store (count zero) and drops any pending result;
// cell contents are not cleared. A result held by a stalled receiver stays in
// the output register; the next request may be taken meanwhile, but its
// result waits until the register is free.
module indexed_sequence_store import isq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]       r_state,  n_state;
    logic [CNT_W-1:0] r_count,  n_count;
    logic [CNT_W-1:0] r_len,    n_len;
    logic             r_phase,  n_phase;
    logic [3:0]       r_act,    n_act;
    logic [CMP_W-1:0] r_pos,    n_pos;
    t_word            r_val,    n_val;
    logic [1:0]       r_status, n_status;
    t_word            r_rd,     n_rd;
    logic             r_out_valid, n_out_valid;
    t_rsp             r_out,    n_out;

    t_word     w_data    [CAPACITY];
    t_word     w_prev    [CAPACITY];
    t_word     w_next    [CAPACITY];
    logic      w_gt      [CAPACITY];
    logic      w_swap    [CAPACITY];
    logic      w_swap_dn [CAPACITY];
    t_cell_cmd w_cmd     [CAPACITY];

    logic             w_accept;
    logic [CMP_W-1:0] w_cnt;
    logic [CMP_W-1:0] w_in_pos;
    logic [1:0]       w_status;
    t_word            w_sel_pos;
    t_word            w_sel_last;

    assign w_accept = i_valid && o_ready;
    assign w_cnt    = CMP_W'(r_count);
    assign w_in_pos = CMP_W'(i_data.position);

    // Build the cell chain with its neighbor links
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_prev[g]    = '0;
            assign w_swap_dn[g] = 1'b0;
        end else begin : g_mid
            assign w_prev[g]    = w_data[g-1];
            assign w_swap_dn[g] = w_swap[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_next[g] = '0;
            assign w_swap[g] = 1'b0;
        end else begin : g_inner
            assign w_next[g] = w_data[g+1];
            assign w_swap[g] = (1'(g) == r_phase) && (CMP_W'(g + 1) < w_cnt) && w_gt[g];
        end

        isq_cell u_cell (
            .i_clk     (i_clk),
            .i_cmd     (w_cmd[g]),
            .i_val     (r_val),
            .i_prev    (w_prev[g]),
            .i_next    (w_next[g]),
            .i_head    (w_data[0]),
            .o_data    (w_data[g]),
            .o_gt_next (w_gt[g])
        );
    end

    // Check the request against the current count
    always_comb begin
        w_status = ST_OK;
        unique case (i_data.action)
            ACT_APPEND, ACT_PREPEND: begin
                if (r_count >= CNT_W'(CAPACITY)) w_status = ST_FULL;
            end
            ACT_REM_FIRST, ACT_REM_LAST: begin
                if (r_count == '0) w_status = ST_EMPTY;
            end
            ACT_READ, ACT_WRITE: begin
                if (w_in_pos >= w_cnt) w_status = ST_INDEX;
            end
            ACT_INSERT: begin
                if (w_in_pos > w_cnt) w_status = ST_INDEX;
                else if (r_count >= CNT_W'(CAPACITY)) w_status = ST_FULL;
            end
            ACT_REM_AT: begin
                if (r_count == '0) w_status = ST_EMPTY;
                else if (w_in_pos >= w_cnt) w_status = ST_INDEX;
            end
            default: w_status = ST_OK;
        endcase
    end

    // Drive each cell's source select
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_cmd[i] = CMD_HOLD;
            if (r_state == S_EXEC && r_status == ST_OK) begin
                unique case (r_act)
                    ACT_APPEND, ACT_PREPEND, ACT_INSERT: begin
                        if (CMP_W'(i) == r_pos) w_cmd[i] = CMD_LOAD;
                        else if (CMP_W'(i) > r_pos && CMP_W'(i) <= w_cnt) w_cmd[i] = CMD_PREV;
                    end
                    ACT_REM_FIRST, ACT_REM_AT: begin
                        if (CMP_W'(i) >= r_pos && CMP_W'(i + 1) < w_cnt) w_cmd[i] = CMD_NEXT;
                    end
                    ACT_WRITE: begin
                        if (CMP_W'(i) == r_pos) w_cmd[i] = CMD_LOAD;
                    end
                    ACT_REVERSE: begin
                        if (r_len >= CNT_W'(2)) begin
                            if (CMP_W'(i + 1) < CMP_W'(r_len)) w_cmd[i] = CMD_NEXT;
                            else if (CMP_W'(i + 1) == CMP_W'(r_len)) w_cmd[i] = CMD_HEAD;
                        end
                    end
                    ACT_SORT: begin
                        if (r_len != '0) begin
                            if (w_swap[i]) w_cmd[i] = CMD_NEXT;
                            else if (w_swap_dn[i]) w_cmd[i] = CMD_PREV;
                        end
                    end
                    default: w_cmd[i] = CMD_HOLD;
                endcase
            end
        end
    end

    // Select the cell at the request position and the last held cell
    always_comb begin
        w_sel_pos  = '0;
        w_sel_last = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (CMP_W'(i) == r_pos) w_sel_pos = w_sel_pos | w_data[i];
            if (CMP_W'(i + 1) == w_cnt) w_sel_last = w_sel_last | w_data[i];
        end
    end

    // Sequence one transaction: latch, execute, report
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_len       = r_len;
        n_phase     = r_phase;
        n_act       = r_act;
        n_pos       = r_pos;
        n_val       = r_val;
        n_status    = r_status;
        n_rd        = r_rd;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_act    = i_data.action;
                    n_val    = i_data.item_value;
                    n_status = w_status;
                    n_len    = r_count;
                    n_phase  = 1'b0;
                    n_rd     = '0;
                    if (i_data.action == ACT_APPEND) n_pos = w_cnt;
                    else if (i_data.action == ACT_PREPEND ||
                             i_data.action == ACT_REM_FIRST) n_pos = '0;
                    else n_pos = w_in_pos;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FIN;
                if (r_status == ST_OK) begin
                    unique case (r_act)
                        ACT_APPEND, ACT_PREPEND, ACT_INSERT: n_count = r_count + CNT_W'(1);
                        ACT_REM_FIRST, ACT_REM_LAST, ACT_REM_AT: n_count = r_count - CNT_W'(1);
                        ACT_CLEAR: n_count = '0;
                        ACT_READ:  n_rd = w_sel_pos;
                        ACT_REVERSE: begin
                            if (r_len >= CNT_W'(2)) begin
                                n_len   = r_len - CNT_W'(1);
                                n_state = S_EXEC;
                            end
                        end
                        ACT_SORT: begin
                            if (r_len != '0) begin
                                n_len   = r_len - CNT_W'(1);
                                n_phase = !r_phase;
                                n_state = S_EXEC;
                            end
                        end
                        default: n_count = r_count;
                    endcase
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_ready) begin
                    n_out.status      = r_status;
                    n_out.read_value  = r_rd;
                    n_out.first_value = (r_count != '0) ? w_data[0] : '0;
                    n_out.last_value  = w_sel_last;
                    n_out.count       = OUT_CNT_W'(r_count);
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold control state under reset, payload runs free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_len       <= '0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_len       <= n_len;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_status <= n_status;
        r_rd     <= n_rd;
        r_out    <= n_out;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== src/isq_checker.sv =====
// Port-level checks of the sequence store and their bind to the top level.
`include "indexed_sequence_store_defines.svh"

module isq_checker import isq_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_rsp i_out_data
);

    // Hold a stalled result
    `ISQ_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data), "result changed while stalled")

    // Empty store reports zero ends
    `ISQ_ASSERT_NOW(a_empty_ends, i_clk, i_rst_n, i_out_valid && i_out_data.count == '0, i_out_data.first_value == '0 && i_out_data.last_value == '0, "nonzero ends on empty store")

    // Full status only at capacity
    `ISQ_ASSERT_NOW(a_full_count, i_clk, i_rst_n, i_out_valid && i_out_data.status == ST_FULL, i_out_data.count == OUT_CNT_W'(CAPACITY), "full status below capacity")

    // Read data only with ok status
    `ISQ_ASSERT_NOW(a_read_ok, i_clk, i_rst_n, i_out_valid && i_out_data.read_value != '0, i_out_data.status == ST_OK, "read value on failed transaction")

endmodule

bind indexed_sequence_store isq_checker u_isq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_out_data  (o_data)
);
